// ===== sv/pxte_pkg.sv =====
`timescale 1ns / 1ps
package pxte_pkg;

  localparam int CW           = 32;
  localparam int AW           = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int RATIO_BITS   = 30;
  localparam int SQRT_GUARD   = 14;
  localparam int CFG_W        = 32;
  localparam int ATAN_W       = 32;
  localparam int ATI_W        = 5;

  localparam int DW    = CW + 1;
  localparam int PW    = 2 * CW + 2;
  localparam int RXW   = CW + 3;
  localparam int MW    = RXW;
  localparam int PRW   = 2 * MW;
  localparam int RW    = PW + 1;
  localparam int NW    = PW + SQRT_GUARD;
  localparam int QW    = CW + 1;
  localparam int SNW   = PW + 2 * SQRT_GUARD;
  localparam int SQW   = SNW / 2;
  localparam int SRW   = SQW + 3;
  localparam int NB    = 48;
  localparam int XW    = NB + 5;
  localparam int DSQ   = 64;
  localparam int CNT_W = $clog2(NW);

  localparam logic [CFG_W-1:0]  MIN_LEN_RESET = CFG_W'(4);
  localparam logic [ATAN_W-1:0] CZ_HALF       = ATAN_W'(1) << (ATAN_W - 1);

  typedef struct packed {
    logic signed [CW-1:0] vehicle_x;
    logic signed [CW-1:0] vehicle_y;
    logic signed [AW-1:0] vehicle_heading;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 first_point;
    logic                 last_point;
  } in_t;

  typedef struct packed {
    logic                 path_valid;
    logic signed [CW-1:0] xtrack_err;
    logic signed [AW-1:0] heading_error;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_DIFF,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_CROSS,
    ST_DIV, ST_MQ0, ST_MQ1, ST_MQ2, ST_MRX, ST_MRY, ST_DIST, ST_END,
    ST_SQI, ST_SQ, ST_DVI, ST_FDV, ST_CI, ST_CN, ST_CR, ST_RES
  } state_t;

  typedef enum logic [3:0] {
    MUL_DXDX, MUL_DYDY, MUL_VXDX, MUL_VYDY, MUL_DXVY, MUL_DYVX,
    MUL_QDX, MUL_QDY, MUL_RXRX, MUL_RYRY
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_LOAD, ACC_LEN, ACC_DOT, ACC_CROSS, ACC_RX, ACC_RY, ACC_DIST
  } acc_op_t;

  typedef struct packed {
    logic             load_item;
    logic             start;
    logic             diff;
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic             r_vec;
    logic             r_end;
    logic             div_init_ratio;
    logic             div_init_final;
    logic             div_step;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             cor_init;
    logic             cor_norm;
    logic             cor_rot;
    logic             seg_end;
    logic             out_load;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic has_prev;
    logic found;
    logic len_ok;
    logic dot_nonpos;
    logic dot_ge_len;
    logic norm_done;
  } sts_t;

  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATI_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/polyline_cross_track_error_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                        Direction  Transfer
// in        in_valid/in_ready/in_data    input      in_valid & in_ready
// out       out_valid/out_ready/out_data output     out_valid & out_ready
// cfg       cfg_we/cfg_wdata             input      cfg_we
//
// One point at a time. A point that closes a segment uses the shared 35x35
// multiplier and, unless the ratio clamps or the segment is degenerate, the
// 30-step ratio divider. A last point, once a segment is found, adds 47
// root steps, 80 divider steps, up to 48 normalising shifts and 16 CORDIC
// steps. Synchronous active-low reset. The result waits in an output
// register; only a further last point stalls.
module polyline_cross_track_error_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pxte_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pxte_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [pxte_pkg::CFG_W-1:0]  cfg_wdata
);

  pxte_pkg::cmd_t cmd;
  pxte_pkg::sts_t sts;

  pxte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pxte_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.path_valid |->
      (out_data.xtrack_err == '0) && (out_data.heading_error == '0))
    else $error("invalid result carries data");
`endif

endmodule

// ===== sv/pxte_ctrl.sv =====
`timescale 1ns / 1ps
module pxte_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pxte_pkg::sts_t  sts,
  output pxte_pkg::cmd_t  cmd
);

  pxte_pkg::state_t                state_r, state_nxt;
  logic [pxte_pkg::CNT_W-1:0]      cnt_r;
  logic                            out_valid_r;
  logic                            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pxte_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pxte_pkg::ST_IDLE:  if (in_valid) state_nxt = pxte_pkg::ST_START;
      pxte_pkg::ST_START: begin
        if (sts.first || !sts.has_prev) state_nxt = pxte_pkg::ST_END;
        else state_nxt = pxte_pkg::ST_DIFF;
      end
      pxte_pkg::ST_DIFF:  state_nxt = pxte_pkg::ST_MUL0;
      pxte_pkg::ST_MUL0:  state_nxt = pxte_pkg::ST_MUL1;
      pxte_pkg::ST_MUL1:  state_nxt = pxte_pkg::ST_MUL2;
      pxte_pkg::ST_MUL2:  state_nxt = pxte_pkg::ST_MUL3;
      pxte_pkg::ST_MUL3:  state_nxt = pxte_pkg::ST_MUL4;
      pxte_pkg::ST_MUL4:  state_nxt = pxte_pkg::ST_MUL5;
      pxte_pkg::ST_MUL5:  state_nxt = pxte_pkg::ST_CROSS;
      pxte_pkg::ST_CROSS: begin
        priority if (!sts.len_ok) state_nxt = pxte_pkg::ST_END;
        else if (sts.dot_nonpos || sts.dot_ge_len) state_nxt = pxte_pkg::ST_MRX;
        else state_nxt = pxte_pkg::ST_DIV;
      end
      pxte_pkg::ST_DIV: begin
        if (cnt_r == pxte_pkg::CNT_W'(pxte_pkg::RATIO_BITS - 1)) state_nxt = pxte_pkg::ST_MQ0;
      end
      pxte_pkg::ST_MQ0:   state_nxt = pxte_pkg::ST_MQ1;
      pxte_pkg::ST_MQ1:   state_nxt = pxte_pkg::ST_MQ2;
      pxte_pkg::ST_MQ2:   state_nxt = pxte_pkg::ST_MRX;
      pxte_pkg::ST_MRX:   state_nxt = pxte_pkg::ST_MRY;
      pxte_pkg::ST_MRY:   state_nxt = pxte_pkg::ST_DIST;
      pxte_pkg::ST_DIST:  state_nxt = pxte_pkg::ST_END;
      pxte_pkg::ST_END: begin
        priority if (!sts.last) state_nxt = pxte_pkg::ST_IDLE;
        else if (sts.found) state_nxt = pxte_pkg::ST_SQI;
        else state_nxt = pxte_pkg::ST_RES;
      end
      pxte_pkg::ST_SQI:   state_nxt = pxte_pkg::ST_SQ;
      pxte_pkg::ST_SQ: begin
        if (cnt_r == pxte_pkg::CNT_W'(pxte_pkg::SQW - 1)) state_nxt = pxte_pkg::ST_DVI;
      end
      pxte_pkg::ST_DVI:   state_nxt = pxte_pkg::ST_FDV;
      pxte_pkg::ST_FDV: begin
        if (cnt_r == pxte_pkg::CNT_W'(pxte_pkg::NW - 1)) state_nxt = pxte_pkg::ST_CI;
      end
      pxte_pkg::ST_CI:    state_nxt = pxte_pkg::ST_CN;
      pxte_pkg::ST_CN:    if (sts.norm_done) state_nxt = pxte_pkg::ST_CR;
      pxte_pkg::ST_CR: begin
        if (cnt_r == pxte_pkg::CNT_W'(pxte_pkg::CORDIC_STEPS - 1)) state_nxt = pxte_pkg::ST_RES;
      end
      pxte_pkg::ST_RES:   if (out_free) state_nxt = pxte_pkg::ST_IDLE;
      default:            state_nxt = pxte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = pxte_pkg::MUL_DXDX;
    cmd.acc_op  = pxte_pkg::ACC_NONE;
    cmd.step    = cnt_r;
    unique case (state_r)
      pxte_pkg::ST_IDLE:  cmd.load_item = in_valid;
      pxte_pkg::ST_START: cmd.start = 1'b1;
      pxte_pkg::ST_DIFF:  cmd.diff = 1'b1;
      pxte_pkg::ST_MUL0:  cmd.mul_sel = pxte_pkg::MUL_DXDX;
      pxte_pkg::ST_MUL1: begin
        cmd.mul_sel = pxte_pkg::MUL_DYDY;
        cmd.acc_op  = pxte_pkg::ACC_LOAD;
      end
      pxte_pkg::ST_MUL2: begin
        cmd.mul_sel = pxte_pkg::MUL_VXDX;
        cmd.acc_op  = pxte_pkg::ACC_LEN;
      end
      pxte_pkg::ST_MUL3: begin
        cmd.mul_sel = pxte_pkg::MUL_VYDY;
        cmd.acc_op  = pxte_pkg::ACC_LOAD;
      end
      pxte_pkg::ST_MUL4: begin
        cmd.mul_sel = pxte_pkg::MUL_DXVY;
        cmd.acc_op  = pxte_pkg::ACC_DOT;
      end
      pxte_pkg::ST_MUL5: begin
        cmd.mul_sel = pxte_pkg::MUL_DYVX;
        cmd.acc_op  = pxte_pkg::ACC_LOAD;
      end
      pxte_pkg::ST_CROSS: begin
        cmd.acc_op         = pxte_pkg::ACC_CROSS;
        cmd.r_vec          = sts.len_ok && sts.dot_nonpos;
        cmd.r_end          = sts.len_ok && !sts.dot_nonpos && sts.dot_ge_len;
        cmd.div_init_ratio = sts.len_ok && !sts.dot_nonpos && !sts.dot_ge_len;
      end
      pxte_pkg::ST_DIV:   cmd.div_step = 1'b1;
      pxte_pkg::ST_MQ0:   cmd.mul_sel = pxte_pkg::MUL_QDX;
      pxte_pkg::ST_MQ1: begin
        cmd.mul_sel = pxte_pkg::MUL_QDY;
        cmd.acc_op  = pxte_pkg::ACC_RX;
      end
      pxte_pkg::ST_MQ2:   cmd.acc_op = pxte_pkg::ACC_RY;
      pxte_pkg::ST_MRX:   cmd.mul_sel = pxte_pkg::MUL_RXRX;
      pxte_pkg::ST_MRY: begin
        cmd.mul_sel = pxte_pkg::MUL_RYRY;
        cmd.acc_op  = pxte_pkg::ACC_LOAD;
      end
      pxte_pkg::ST_DIST:  cmd.acc_op = pxte_pkg::ACC_DIST;
      pxte_pkg::ST_END:   cmd.seg_end = 1'b1;
      pxte_pkg::ST_SQI:   cmd.sqrt_init = 1'b1;
      pxte_pkg::ST_SQ:    cmd.sqrt_step = 1'b1;
      pxte_pkg::ST_DVI:   cmd.div_init_final = 1'b1;
      pxte_pkg::ST_FDV:   cmd.div_step = 1'b1;
      pxte_pkg::ST_CI:    cmd.cor_init = 1'b1;
      pxte_pkg::ST_CN:    cmd.cor_norm = !sts.norm_done;
      pxte_pkg::ST_CR:    cmd.cor_rot = 1'b1;
      pxte_pkg::ST_RES:   cmd.out_load = out_free;
      default:            cmd.step = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pxte_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt == state_r) ? cnt_r + pxte_pkg::CNT_W'(1) : '0;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== sv/pxte_dpath.sv =====
`timescale 1ns / 1ps
module pxte_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pxte_pkg::CFG_W-1:0]  cfg_wdata,
  input  pxte_pkg::in_t               in_data,
  input  pxte_pkg::cmd_t              cmd,
  output pxte_pkg::sts_t              sts,
  output pxte_pkg::out_t              out_data
);

  localparam int CW  = pxte_pkg::CW;
  localparam int AW  = pxte_pkg::AW;
  localparam int DW  = pxte_pkg::DW;
  localparam int PW  = pxte_pkg::PW;
  localparam int RXW = pxte_pkg::RXW;
  localparam int MW  = pxte_pkg::MW;
  localparam int PRW = pxte_pkg::PRW;
  localparam int RW  = pxte_pkg::RW;
  localparam int NW  = pxte_pkg::NW;
  localparam int QW  = pxte_pkg::QW;
  localparam int SNW = pxte_pkg::SNW;
  localparam int SQW = pxte_pkg::SQW;
  localparam int SRW = pxte_pkg::SRW;
  localparam int NB  = pxte_pkg::NB;
  localparam int XW  = pxte_pkg::XW;
  localparam int DSQ = pxte_pkg::DSQ;
  localparam int AT  = pxte_pkg::ATAN_W;
  localparam int RB  = pxte_pkg::RATIO_BITS;
  localparam int SG  = pxte_pkg::SQRT_GUARD;
  localparam logic [QW-1:0] LIM = QW'(1) << (CW - 1);

  pxte_pkg::in_t              item_r;
  logic [pxte_pkg::CFG_W-1:0] min_len_r;
  logic signed [CW-1:0]       pose_x_r, pose_y_r, prev_x_r, prev_y_r;
  logic [AW-1:0]              pose_h_r;
  logic                       has_prev_r, found_r;
  logic [DSQ-1:0]             best_dist_r;
  logic signed [DW-1:0]       best_dx_r, best_dy_r;
  logic signed [PW-1:0]       best_cross_r;
  logic [PW-1:0]              best_len_r;

  logic signed [DW-1:0]       dx_r, dy_r, vx_r, vy_r;
  logic signed [MW-1:0]       mul_a, mul_b;
  logic signed [PRW-1:0]      prod_r, acc_r;
  logic [PW-1:0]              len_r;
  logic signed [PW-1:0]       dot_r, cross_r;
  logic signed [RXW-1:0]      rx_r, ry_r;
  logic [DW-1:0]              dx_mag, dy_mag;
  logic signed [PRW-1:0]      rnd, dist_sum;
  logic signed [RXW-1:0]      tv;
  logic [DSQ-1:0]             d64;

  logic [RW-1:0]              drem_r, dsh;
  logic [NW-1:0]              dnum_r;
  logic [QW-1:0]              dquo_r;
  logic                       dovf_r, dge;
  logic [PW-1:0]              ddiv_r;

  logic [SNW-1:0]             sq_n_r;
  logic [SRW-1:0]             sq_rem_r, sq_r4, sq_trial;
  logic [SQW-1:0]             sq_root_r, sq_s;

  logic signed [XW-1:0]       cx_r, cy_r, bx, by, xs, ys;
  logic [AT-1:0]              cz_r, seg_sum, at_v;
  logic                       x_small, y_small;

  logic [PW-1:0]              cross_mag;
  logic                       pos_big, neg_big;
  logic [QW-1:0]              neg_mag;
  logic signed [CW-1:0]       lat;
  logic [AW-1:0]              hdg;
  pxte_pkg::out_t             out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) min_len_r <= pxte_pkg::MIN_LEN_RESET;
    else if (cfg_we) min_len_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
  end

  // pose and search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
      has_prev_r  <= 1'b0;
      found_r     <= 1'b0;
      best_dist_r <= '1;
    end else begin
      if (cmd.start && item_r.first_point) begin
        pose_x_r    <= item_r.vehicle_x;
        pose_y_r    <= item_r.vehicle_y;
        pose_h_r    <= item_r.vehicle_heading;
        has_prev_r  <= 1'b0;
        found_r     <= 1'b0;
        best_dist_r <= '1;
      end
      if (cmd.seg_end) has_prev_r <= 1'b1;
      if (cmd.acc_op == pxte_pkg::ACC_DIST && (!found_r || d64 < best_dist_r)) begin
        found_r     <= 1'b1;
        best_dist_r <= d64;
      end
      if (cmd.out_load) begin
        has_prev_r  <= 1'b0;
        found_r     <= 1'b0;
        best_dist_r <= '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_end) begin
      prev_x_r <= item_r.point_x;
      prev_y_r <= item_r.point_y;
    end
    if (cmd.acc_op == pxte_pkg::ACC_DIST && (!found_r || d64 < best_dist_r)) begin
      best_dx_r    <= dx_r;
      best_dy_r    <= dy_r;
      best_cross_r <= cross_r;
      best_len_r   <= len_r;
    end
  end

  // segment vectors
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_r <= DW'(item_r.point_x) - DW'(prev_x_r);
      dy_r <= DW'(item_r.point_y) - DW'(prev_y_r);
      vx_r <= DW'(pose_x_r) - DW'(prev_x_r);
      vy_r <= DW'(pose_y_r) - DW'(prev_y_r);
    end
  end

  assign dx_mag = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign dy_mag = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  always_comb begin
    mul_a = MW'(dx_r);
    mul_b = MW'(dx_r);
    unique case (cmd.mul_sel)
      pxte_pkg::MUL_DXDX: begin mul_a = MW'(dx_r); mul_b = MW'(dx_r); end
      pxte_pkg::MUL_DYDY: begin mul_a = MW'(dy_r); mul_b = MW'(dy_r); end
      pxte_pkg::MUL_VXDX: begin mul_a = MW'(vx_r); mul_b = MW'(dx_r); end
      pxte_pkg::MUL_VYDY: begin mul_a = MW'(vy_r); mul_b = MW'(dy_r); end
      pxte_pkg::MUL_DXVY: begin mul_a = MW'(dx_r); mul_b = MW'(vy_r); end
      pxte_pkg::MUL_DYVX: begin mul_a = MW'(dy_r); mul_b = MW'(vx_r); end
      pxte_pkg::MUL_QDX: begin
        mul_a = MW'(dquo_r[RB-1:0]);
        mul_b = MW'(dx_mag);
      end
      pxte_pkg::MUL_QDY: begin
        mul_a = MW'(dquo_r[RB-1:0]);
        mul_b = MW'(dy_mag);
      end
      pxte_pkg::MUL_RXRX: begin mul_a = rx_r; mul_b = rx_r; end
      pxte_pkg::MUL_RYRY: begin mul_a = ry_r; mul_b = ry_r; end
      default: begin mul_a = MW'(dx_r); mul_b = MW'(dx_r); end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign rnd      = prod_r + (PRW'(1) <<< (RB - 1));
  assign tv       = RXW'(rnd >>> RB);
  assign dist_sum = acc_r + prod_r;
  assign d64      = (|dist_sum[PRW-1:DSQ]) ? '1 : dist_sum[DSQ-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      pxte_pkg::ACC_LOAD:  acc_r <= prod_r;
      pxte_pkg::ACC_LEN:   len_r <= PW'(acc_r + prod_r);
      pxte_pkg::ACC_DOT:   dot_r <= PW'(acc_r + prod_r);
      pxte_pkg::ACC_CROSS: cross_r <= PW'(acc_r - prod_r);
      pxte_pkg::ACC_RX:    rx_r <= dx_r[DW-1] ? RXW'(vx_r) + tv : RXW'(vx_r) - tv;
      pxte_pkg::ACC_RY:    ry_r <= dy_r[DW-1] ? RXW'(vy_r) + tv : RXW'(vy_r) - tv;
      default: ;
    endcase
    if (cmd.r_vec) begin
      rx_r <= RXW'(vx_r);
      ry_r <= RXW'(vy_r);
    end
    if (cmd.r_end) begin
      rx_r <= RXW'(vx_r) - RXW'(dx_r);
      ry_r <= RXW'(vy_r) - RXW'(dy_r);
    end
  end

  // shared restoring divider
  assign dsh = {drem_r[RW-2:0], dnum_r[NW-1]};
  assign dge = (dsh >= {1'b0, ddiv_r});
  assign sq_s = (sq_root_r == '0) ? SQW'(1) : sq_root_r;
  assign cross_mag = best_cross_r[PW-1] ? PW'(-best_cross_r) : PW'(best_cross_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dovf_r <= 1'b0;
    end else begin
      priority if (cmd.div_init_ratio || cmd.div_init_final) dovf_r <= 1'b0;
      else if (cmd.div_step) dovf_r <= dovf_r | dquo_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.div_init_ratio) begin
      drem_r <= RW'($unsigned(dot_r));
      dnum_r <= '0;
      dquo_r <= '0;
      ddiv_r <= len_r;
    end else if (cmd.div_init_final) begin
      drem_r <= '0;
      dnum_r <= {cross_mag, {SG{1'b0}}};
      dquo_r <= '0;
      ddiv_r <= PW'(sq_s);
    end else if (cmd.div_step) begin
      drem_r <= dge ? dsh - {1'b0, ddiv_r} : dsh;
      dnum_r <= {dnum_r[NW-2:0], 1'b0};
      dquo_r <= {dquo_r[QW-2:0], dge};
    end
  end

  // square root, two radicand bits per step
  assign sq_r4    = {sq_rem_r[SRW-3:0], sq_n_r[SNW-1:SNW-2]};
  assign sq_trial = SRW'({sq_root_r, 2'b01});

  always_ff @(posedge clk) begin
    priority if (cmd.sqrt_init) begin
      sq_n_r    <= {best_len_r, {(2 * SG){1'b0}}};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sq_n_r <= {sq_n_r[SNW-3:0], 2'b00};
      if (sq_r4 >= sq_trial) begin
        sq_rem_r  <= sq_r4 - sq_trial;
        sq_root_r <= {sq_root_r[SQW-2:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_r4;
        sq_root_r <= {sq_root_r[SQW-2:0], 1'b0};
      end
    end
  end

  // CORDIC vectoring
  assign bx = XW'(best_dx_r);
  assign by = XW'(best_dy_r);
  assign x_small = (cx_r[XW-1:NB] == '0) || ((&cx_r[XW-1:NB]) && (cx_r[NB-1:0] != '0));
  assign y_small = (cy_r[XW-1:NB] == '0) || ((&cy_r[XW-1:NB]) && (cy_r[NB-1:0] != '0));
  assign xs   = cx_r >>> cmd.step[pxte_pkg::ATI_W-1:0];
  assign ys   = cy_r >>> cmd.step[pxte_pkg::ATI_W-1:0];
  assign at_v = pxte_pkg::atan_lut(cmd.step[pxte_pkg::ATI_W-1:0]);

  always_ff @(posedge clk) begin
    priority if (cmd.cor_init) begin
      if (best_dx_r[DW-1]) begin
        cx_r <= -bx;
        cy_r <= -by;
        cz_r <= pxte_pkg::CZ_HALF;
      end else begin
        cx_r <= bx;
        cy_r <= by;
        cz_r <= '0;
      end
    end else if (cmd.cor_norm) begin
      cx_r <= cx_r <<< 1;
      cy_r <= cy_r <<< 1;
    end else if (cmd.cor_rot) begin
      if (!cy_r[XW-1]) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at_v;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at_v;
      end
    end
  end

  // result
  assign seg_sum = cz_r + (AT'(1) << (AT - 1 - AW));
  assign hdg     = pose_h_r - seg_sum[AT-1 -: AW];
  assign pos_big = dovf_r || (dquo_r > LIM - QW'(1));
  assign neg_big = dovf_r || (dquo_r > LIM);
  assign neg_mag = neg_big ? LIM : dquo_r;
  assign lat     = best_cross_r[PW-1] ? CW'(QW'(0) - neg_mag)
                                      : (pos_big ? CW'(LIM - QW'(1)) : dquo_r[CW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.path_valid    <= found_r;
      out_r.xtrack_err    <= found_r ? lat : '0;
      out_r.heading_error <= found_r ? hdg : '0;
    end
  end

  assign out_data = out_r;

  assign sts.first      = item_r.first_point;
  assign sts.last       = item_r.last_point;
  assign sts.has_prev   = has_prev_r;
  assign sts.found      = found_r;
  assign sts.len_ok     = len_r > PW'(min_len_r);
  assign sts.dot_nonpos = dot_r[PW-1] || (dot_r == '0);
  assign sts.dot_ge_len = $unsigned(dot_r) >= len_r;
  assign sts.norm_done  = !(x_small && y_small);

endmodule

// ===== dv/polyline_cross_track_error_core_tb.sv =====
`timescale 1ns / 1ps
module polyline_cross_track_error_core_tb;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pxte_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pxte_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [pxte_pkg::CFG_W-1:0] cfg_wdata = '0;

  polyline_cross_track_error_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  pxte_pkg::in_t pending_pts[$];
  pxte_pkg::out_t expected_res[$];
  int errors = 0;
  bit no_idle = 1'b0;

  // tracker state
  logic [pxte_pkg::CFG_W-1:0] min_len = pxte_pkg::MIN_LEN_RESET;
  longint prv_x = 0, prv_y = 0, veh_x = 0, veh_y = 0;
  logic [pxte_pkg::AW-1:0] veh_h = '0;
  bit have_prev = 0, have_best = 0;
  logic [63:0] best_d = '1;
  longint best_dx = 0, best_dy = 0;
  wide_t best_crs = '0;

  function automatic wide_t wx(longint v);
    wide_t r;
    r = v;
    return r;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scale_ratio(logic [63:0] q, longint d);
    wide_t t;
    longint tv;
    t = wx(longint'(q)) * wx(absl(d)) + (wide_t'(1) <<< (pxte_pkg::RATIO_BITS - 1));
    t = t >>> pxte_pkg::RATIO_BITS;
    tv = t[63:0];
    return d < 0 ? -tv : tv;
  endfunction

  task automatic fold_segment(longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, vx, vy, rx, ry;
    wide_t len, dot, crs, dsq, rem;
    logic [63:0] q, d64;
    dx = ex - sx;
    dy = ey - sy;
    len = wx(dx) * wx(dx) + wx(dy) * wx(dy);
    if (len <= $signed({96'b0, min_len})) return;
    vx = veh_x - sx;
    vy = veh_y - sy;
    dot = wx(vx) * wx(dx) + wx(vy) * wx(dy);
    crs = wx(dx) * wx(vy) - wx(dy) * wx(vx);
    if (dot <= 0) begin
      rx = vx; ry = vy;
    end else if (dot >= len) begin
      rx = vx - dx; ry = vy - dy;
    end else begin
      rem = dot;
      q = 0;
      for (int k = 0; k < pxte_pkg::RATIO_BITS; k++) begin
        rem = rem <<< 1;
        q = q << 1;
        if (rem >= len) begin
          rem = rem - len;
          q[0] = 1'b1;
        end
      end
      rx = vx - scale_ratio(q, dx);
      ry = vy - scale_ratio(q, dy);
    end
    dsq = wx(rx) * wx(rx) + wx(ry) * wx(ry);
    d64 = (dsq[127:64] != 0) ? '1 : dsq[63:0];
    if (!have_best || d64 < best_d) begin
      have_best = 1;
      best_d = d64;
      best_dx = dx;
      best_dy = dy;
      best_crs = crs;
    end
  endtask

  function automatic logic [31:0] seg_bearing(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    if (x == 0 && y == 0) return z;
    while (absl(x) < (longint'(1) <<< 48) && absl(y) < (longint'(1) <<< 48)) begin
      x = x * 2; y = y * 2;
    end
    for (int i = 0; i < pxte_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + pxte_pkg::atan_lut(pxte_pkg::ATI_W'(i));
      end else begin
        x = x - ys; y = y + xs; z = z - pxte_pkg::atan_lut(pxte_pkg::ATI_W'(i));
      end
    end
    return z;
  endfunction

  function automatic pxte_pkg::out_t path_result();
    pxte_pkg::out_t r;
    logic [127:0] n, m, qq, cc, lim;
    logic [63:0] s, c;
    logic [31:0] z, sg;
    bit neg;
    r = '0;
    if (!have_best) return r;
    r.path_valid = 1'b1;
    n = (wx(best_dx) * wx(best_dx) + wx(best_dy) * wx(best_dy)) << (2 * pxte_pkg::SQRT_GUARD);
    s = 0;
    for (int b = 63; b >= 0; b--) begin
      c = s | (64'd1 << b);
      cc = {64'b0, c} * {64'b0, c};
      if (n >= cc) s = c;
    end
    if (s == 0) s = 1;
    neg = best_crs < 0;
    m = neg ? -best_crs : best_crs;
    qq = (m << pxte_pkg::SQRT_GUARD) / {64'b0, s};
    lim = 128'd1 << (pxte_pkg::CW - 1);
    if (neg) r.xtrack_err = (qq > lim) ? -lim[pxte_pkg::CW-1:0] : -qq[pxte_pkg::CW-1:0];
    else r.xtrack_err = (qq > lim - 1) ? lim[pxte_pkg::CW-1:0] - 1 : qq[pxte_pkg::CW-1:0];
    z = seg_bearing(best_dx, best_dy);
    sg = (z + (32'd1 << (31 - pxte_pkg::AW))) >> (32 - pxte_pkg::AW);
    r.heading_error = veh_h - sg[pxte_pkg::AW-1:0];
    return r;
  endfunction

  task automatic track_point(pxte_pkg::in_t it);
    longint px, py;
    px = it.point_x;
    py = it.point_y;
    if (it.first_point) begin
      veh_x = it.vehicle_x;
      veh_y = it.vehicle_y;
      veh_h = it.vehicle_heading;
      have_prev = 0; have_best = 0; best_d = '1;
    end
    if (have_prev) fold_segment(prv_x, prv_y, px, py);
    prv_x = px;
    prv_y = py;
    have_prev = 1;
    if (it.last_point) begin
      expected_res.push_back(path_result());
      have_prev = 0; have_best = 0; best_d = '1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) track_point(in_data);
      if (pending_pts.size() > 0 && (no_idle || $urandom_range(0, 99) >= 34)) begin
        in_data <= pending_pts.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pxte_pkg::out_t e;
    out_ready <= no_idle || ($urandom_range(0, 99) >= 34);
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_data);
      end else begin
        e = expected_res.pop_front();
        if (e.path_valid !== out_data.path_valid) begin
          errors++;
          $display("%0t path_valid exp %b act %b", $time, e.path_valid, out_data.path_valid);
        end
        if (e.xtrack_err !== out_data.xtrack_err) begin
          errors++;
          $display("%0t xtrack_err exp %h act %h", $time, e.xtrack_err,
                   out_data.xtrack_err);
        end
        if (e.heading_error !== out_data.heading_error) begin
          errors++;
          $display("%0t heading_error exp %h act %h", $time, e.heading_error,
                   out_data.heading_error);
        end
      end
    end
  end

  // watchdog on transfers
  int stall_cnt = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 20000) begin
      $display("polyline_cross_track_error_core regression: fail");
      $finish;
    end
  end

  task automatic put(longint vx, longint vy, int h, longint px, longint py, bit f, bit l);
    pxte_pkg::in_t it;
    it.vehicle_x = vx[31:0];
    it.vehicle_y = vy[31:0];
    it.vehicle_heading = h[15:0];
    it.point_x = px[31:0];
    it.point_y = py[31:0];
    it.first_point = f;
    it.last_point = l;
    pending_pts.push_back(it);
  endtask

  function automatic longint pick_coord(longint base);
    case ($urandom_range(0, 9))
      0: return longint'($signed($urandom()));
      1: begin
        case ($urandom_range(0, 3))
          0: return -64'sd2147483648;
          1: return 2147483647;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return base + $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
  endfunction

  task automatic rand_path();
    int n;
    longint bx, by, px, py;
    bit f, l;
    n = $urandom_range(1, 7);
    bx = longint'($signed($urandom())) >>> $urandom_range(0, 12);
    by = longint'($signed($urandom())) >>> $urandom_range(0, 12);
    px = pick_coord(bx);
    py = pick_coord(by);
    for (int i = 0; i < n; i++) begin
      f = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 39) == 0);
      l = (i == n - 1) ? ($urandom_range(0, 19) != 0) : 1'b0;
      if (i > 0 && $urandom_range(0, 7) != 0) begin
        px = pick_coord(px);
        py = pick_coord(py);
      end
      put(pick_coord(bx), pick_coord(by), $urandom(), px, py, f, l);
    end
  endtask

  task automatic set_min_len(logic [pxte_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_len = v;
  endtask

  task automatic drain();
    while (pending_pts.size() != 0 || in_valid || expected_res.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  localparam longint MAXC = 64'sd2147483647;
  localparam longint MINC = -64'sd2147483648;

  initial begin
    logic [pxte_pkg::CFG_W-1:0] settings[6];
    settings = '{pxte_pkg::MIN_LEN_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1 << 20, 32'd0, 32'd4};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // path with no first mark after reset
    put(0, 0, 0, 65536, 65536, 0, 0);
    put(0, 0, 0, 3 * 65536, 65536, 0, 1);
    // one-point path
    put(1000, 2000, 16'h7FFF, 5, 5, 1, 1);
    // interior, before start, past end
    put(65536, 65536, 100, 0, 0, 1, 0);
    put(0, 0, 0, 4 * 65536, 0, 0, 1);
    put(-65536, -2000, 16'h8000, 0, 0, 1, 0);
    put(0, 0, 0, 0, 4 * 65536, 0, 1);
    put(9 * 65536, 3, -1, 0, 0, 1, 0);
    put(0, 0, 0, 65536, -65536, 0, 1);
    // degenerate then good, all degenerate
    put(7, 7, 1, 10, 10, 1, 0);
    put(0, 0, 0, 11, 10, 0, 0);
    put(0, 0, 0, 500, 900, 0, 1);
    put(7, 7, 1, 10, 10, 1, 0);
    put(0, 0, 0, 10, 10, 0, 0);
    put(0, 0, 0, 11, 11, 0, 1);
    // tie on collinear segments, restart mid-path
    put(65536, 65536, 0, 0, 0, 1, 0);
    put(0, 0, 0, 65536, 0, 0, 0);
    put(0, 0, 0, 2 * 65536, 0, 0, 0);
    put(3, 3, 3, 2, 2, 1, 0);
    put(0, 0, 0, 9000, -40, 0, 1);
    // extremes, saturating both ways
    put(MINC, MAXC, 16'h8000, MINC, MINC, 1, 0);
    put(MAXC, MINC, 16'h7FFF, MAXC, MINC, 0, 1);
    put(MAXC, MINC, 0, MINC, MINC, 1, 0);
    put(0, 0, 0, MAXC, MINC, 0, 1);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_min_len(ph == 4 ? $urandom() : settings[ph]);
      no_idle = (ph == 2);
      while (pending_pts.size() < 320) rand_path();
      drain();
    end
    if (errors == 0) begin
      $display("polyline_cross_track_error_core regression: pass");
    end else begin
      $display("polyline_cross_track_error_core regression: fail");
    end
    $finish;
  end
endmodule
